// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent assertions clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define PFAQ_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define PFAQ_ASSERT_NEXT(label, ante, cons, msg) \
   `PFAQ_ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// File: sv/pfaq_pkg.sv
// ----------------------------------------------------------------------------
// pfaq_pkg
// Types and constants shared by the persistent fault alarm qualifier.
// ----------------------------------------------------------------------------
package pfaq_pkg;

   localparam int CH_W      = 4;
   localparam int LIMIT_W   = 16;
   localparam int PERSIST_W = 12;
   localparam int CHANNELS  = 16;
   localparam int IDX_W     = 3;

   // Channel classes by alarm bit position.
   localparam logic [CH_W-1:0] CH_NONE          = 4'd0;
   localparam logic [CH_W-1:0] CH_FORWARD       = 4'd1;
   localparam logic [CH_W-1:0] CH_REFLECTED     = 4'd2;
   localparam logic [CH_W-1:0] CH_CURRENT_FIRST = 4'd3;
   localparam logic [CH_W-1:0] CH_CURRENT_LAST  = 4'd6;

   // Alarm word groups for the LED drives.
   localparam logic [LIMIT_W-1:0] CURRENT_MASK     = 16'h0078;
   localparam logic [LIMIT_W-1:0] TEMPERATURE_MASK = 16'hFF80;
   localparam logic [LIMIT_W-1:0] WORD_MASK        = 16'hFFFE;

   // Register reset values.
   localparam logic [LIMIT_W-1:0]   FORWARD_LIMIT_RST       = 16'd2400;
   localparam logic [LIMIT_W-1:0]   REFLECTED_LIMIT_RST     = 16'd2200;
   localparam logic [LIMIT_W-1:0]   CURRENT_HIGH_RST        = 16'd230;
   localparam logic [LIMIT_W-1:0]   CURRENT_LOW_RST         = 16'd4;
   localparam logic [LIMIT_W-1:0]   TEMPERATURE_LIMIT_RST   = 16'd700;
   localparam logic [PERSIST_W-1:0] POWER_PERSIST_RST       = 12'd50;
   localparam logic [PERSIST_W-1:0] CURRENT_PERSIST_RST     = 12'd900;
   localparam logic [PERSIST_W-1:0] TEMPERATURE_PERSIST_RST = 12'd3000;

   // Register indexes on the configuration port.
   typedef enum logic [IDX_W-1:0] {
      REG_FORWARD_LIMIT       = 3'd0,
      REG_REFLECTED_LIMIT     = 3'd1,
      REG_CURRENT_HIGH        = 3'd2,
      REG_CURRENT_LOW         = 3'd3,
      REG_TEMPERATURE_LIMIT   = 3'd4,
      REG_POWER_PERSIST       = 3'd5,
      REG_CURRENT_PERSIST     = 3'd6,
      REG_TEMPERATURE_PERSIST = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]   forward_limit;
      logic [LIMIT_W-1:0]   reflected_limit;
      logic [LIMIT_W-1:0]   current_high;
      logic [LIMIT_W-1:0]   current_low;
      logic [LIMIT_W-1:0]   temperature_limit;
      logic [PERSIST_W-1:0] power_persist;
      logic [PERSIST_W-1:0] current_persist;
      logic [PERSIST_W-1:0] temperature_persist;
   } cfg_type;

   // Classified request handed to the update stage.
   typedef struct packed {
      logic [CH_W-1:0]      channel;
      logic                 fault;
      logic [PERSIST_W-1:0] limit;
   } cls_type;

   typedef struct packed {
      logic                 temperature_led;
      logic                 current_led;
      logic                 reflected_led;
      logic [LIMIT_W-1:0]   alarm_word;
   } rsp_type;

endpackage

// File: sv/pfaq_ram.sv
// ----------------------------------------------------------------------------
// pfaq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfaq_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port; a read at the address being
   // written returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/pfaq_classify.sv
// ----------------------------------------------------------------------------
// pfaq_classify
// Decides whether a sample is faulty and picks its persistence limit.
// ----------------------------------------------------------------------------
module pfaq_classify import pfaq_pkg::*; (
   input  logic [CH_W-1:0]    channel,
   input  logic [LIMIT_W-1:0] sample,
   input  logic               rf_enabled,
   input  cfg_type            cfg,
   output cls_type            cls
);

   logic [PERSIST_W-1:0] limit_raw;

   // Threshold compare and limit selection by channel class.
   always_comb begin
      cls.channel = channel;
      if (channel == CH_FORWARD) begin
         cls.fault = sample > cfg.forward_limit;
         limit_raw = cfg.power_persist;
      end else if (channel == CH_REFLECTED) begin
         cls.fault = sample > cfg.reflected_limit;
         limit_raw = cfg.power_persist;
      end else if (channel inside {[CH_CURRENT_FIRST:CH_CURRENT_LAST]}) begin
         cls.fault = (sample > cfg.current_high) ||
                     ((sample < cfg.current_low) && rf_enabled);
         limit_raw = cfg.current_persist;
      end else begin
         cls.fault = sample > cfg.temperature_limit;
         limit_raw = cfg.temperature_persist;
      end
      // A limit of zero acts as a limit of one.
      cls.limit = (limit_raw == '0) ? PERSIST_W'(1) : limit_raw;
   end

endmodule

// File: sv/persistent_fault_alarm_qualifier.sv
// ----------------------------------------------------------------------------
// persistent_fault_alarm_qualifier
// Per-channel persistence counting of threshold faults into an alarm word.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless the result side stalls;
// each request passes the update stage, then the result register. The
// counters sit in a 16-entry RAM with a registered read: a request reads its
// channel's counter as it is accepted, and the following update stage writes
// it back. A request for the channel just updated takes the written value
// from a forwarding register, so back-to-back requests on one channel need no
// bubble. Counters start at zero through per-entry valid bits, so there is no
// clearing pass after reset. A result register decouples the result side:
// while a finished result waits to be taken, one more request is accepted
// into the update stage, and the input then stalls until the result leaves.
// ----------------------------------------------------------------------------
module persistent_fault_alarm_qualifier import pfaq_pkg::*; #(
   parameter int COUNTER_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [3:0] channel, [19:4] sample, [20] rf_enabled, [23:21] zero
   input  logic [23:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [15:0] alarm_word, [16] reflected_led, [17] current_led,
   // [18] temperature_led, [23:19] zero
   output logic [23:0]          rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int CMP_W = (COUNTER_BITS > PERSIST_W) ? COUNTER_BITS : PERSIST_W;
   localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

   cfg_type                 cfg_ff;
   cls_type                 cls;
   cls_type                 s1_ff;
   logic                    s1_valid_ff;
   logic                    s1_advance;
   logic                    accept;
   logic [COUNTER_BITS-1:0] ram_rd_data;
   logic [CHANNELS-1:0]     cnt_valid_ff;
   logic                    fwd_valid_ff;
   logic [CH_W-1:0]         fwd_ch_ff;
   logic [COUNTER_BITS-1:0] fwd_cnt_ff;
   logic [COUNTER_BITS-1:0] cur_cnt;
   logic [COUNTER_BITS-1:0] inc_cnt;
   logic [COUNTER_BITS-1:0] new_cnt_in;
   logic                    set_bit;
   logic                    wr_en;
   logic [LIMIT_W-1:0]      alarm_ff;
   logic [LIMIT_W-1:0]      alarm_in;
   logic [LIMIT_W-1:0]      bit_mask;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;

   // Handshake: the update stage moves on when the result register is free or its result is taken.
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_limit       <= FORWARD_LIMIT_RST;
         cfg_ff.reflected_limit     <= REFLECTED_LIMIT_RST;
         cfg_ff.current_high        <= CURRENT_HIGH_RST;
         cfg_ff.current_low         <= CURRENT_LOW_RST;
         cfg_ff.temperature_limit   <= TEMPERATURE_LIMIT_RST;
         cfg_ff.power_persist       <= POWER_PERSIST_RST;
         cfg_ff.current_persist     <= CURRENT_PERSIST_RST;
         cfg_ff.temperature_persist <= TEMPERATURE_PERSIST_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FORWARD_LIMIT:       cfg_ff.forward_limit       <= csr_wdata;
            REG_REFLECTED_LIMIT:     cfg_ff.reflected_limit     <= csr_wdata;
            REG_CURRENT_HIGH:        cfg_ff.current_high        <= csr_wdata;
            REG_CURRENT_LOW:         cfg_ff.current_low         <= csr_wdata;
            REG_TEMPERATURE_LIMIT:   cfg_ff.temperature_limit   <= csr_wdata;
            REG_POWER_PERSIST:       cfg_ff.power_persist       <= csr_wdata[PERSIST_W-1:0];
            REG_CURRENT_PERSIST:     cfg_ff.current_persist     <= csr_wdata[PERSIST_W-1:0];
            REG_TEMPERATURE_PERSIST: cfg_ff.temperature_persist <= csr_wdata[PERSIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Fault decision on the incoming request.
   pfaq_classify u_classify (
      .channel    (req_tdata[3:0]),
      .sample     (req_tdata[19:4]),
      .rf_enabled (req_tdata[20]),
      .cfg        (cfg_ff),
      .cls        (cls)
   );

   // Counter memory: read on accept, written back by the update stage.
   pfaq_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (CHANNELS)
   ) u_counters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.channel),
      .wr_data (new_cnt_in),
      .rd_en   (accept),
      .rd_addr (cls.channel),
      .rd_data (ram_rd_data)
   );

   // Update stage: forwarded, stored or zero counter, saturating increment, alarm word.
   always_comb begin
      if (fwd_valid_ff && (fwd_ch_ff == s1_ff.channel)) begin
         cur_cnt = fwd_cnt_ff;
      end else if (cnt_valid_ff[s1_ff.channel]) begin
         cur_cnt = ram_rd_data;
      end else begin
         cur_cnt = '0;
      end
      inc_cnt = (cur_cnt == COUNTER_MAX) ? cur_cnt : cur_cnt + COUNTER_BITS'(1);
      if (!s1_ff.fault) begin
         new_cnt_in = '0;
         set_bit    = 1'b0;
      end else if (CMP_W'(inc_cnt) >= CMP_W'(s1_ff.limit)) begin
         new_cnt_in = COUNTER_BITS'(CMP_W'(s1_ff.limit));
         set_bit    = 1'b1;
      end else begin
         new_cnt_in = inc_cnt;
         set_bit    = 1'b0;
      end
      wr_en    = s1_valid_ff && s1_advance && (s1_ff.channel != CH_NONE);
      bit_mask = LIMIT_W'(1) << s1_ff.channel;
      alarm_in = alarm_ff;
      if (s1_ff.channel != CH_NONE) begin
         alarm_in = set_bit ? (alarm_ff | bit_mask) : (alarm_ff & ~bit_mask);
      end
      alarm_in = alarm_in & WORD_MASK;
      rsp_in.alarm_word      = alarm_in;
      rsp_in.reflected_led   = alarm_in[CH_REFLECTED];
      rsp_in.current_led     = |(alarm_in & CURRENT_MASK);
      rsp_in.temperature_led = |(alarm_in & TEMPERATURE_MASK);
   end

   // Pipeline control, valid bits, forwarding and alarm state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
         alarm_ff     <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_advance) begin
            rsp_valid_ff <= 1'b1;
            alarm_ff     <= alarm_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            cnt_valid_ff[s1_ff.channel] <= 1'b1;
            fwd_valid_ff                <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= cls;
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         fwd_ch_ff  <= s1_ff.channel;
         fwd_cnt_ff <= new_cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.temperature_led, rsp_ff.current_led,
                        rsp_ff.reflected_led, rsp_ff.alarm_word};

endmodule

// File: sv/pfaq_checker.sv
// ----------------------------------------------------------------------------
// pfaq_checker
// Port-level checks on the alarm qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfaq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic req_fire;
   logic rsp_stall;
   logic led_ok;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // LED drives agree with the alarm word, and bit 0 never rises.
   assign led_ok = (rsp_tdata[0] == 1'b0) && (rsp_tdata[16] == rsp_tdata[2]) &&
                   (rsp_tdata[17] == (|rsp_tdata[6:3])) &&
                   (rsp_tdata[18] == (|rsp_tdata[15:7]));

   `PFAQ_ASSERT_CLK(a_led_match, rsp_tvalid |-> led_ok, "LED drives disagree with alarm word")

   // A stalled result stays put.
   `PFAQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result not held")

   // Every accepted request finds a valid result once it has passed the update stage and the result register.
   `PFAQ_ASSERT_CLK(a_latency, req_fire |-> ##2 rsp_tvalid, "no result two cycles after request")

   // No result appears without a request that was accepted and passed the update stage.
   `PFAQ_ASSERT_CLK(a_no_phantom, $rose(rsp_tvalid) |-> $past(req_fire, 2), "result without request")

endmodule

bind persistent_fault_alarm_qualifier pfaq_checker u_pfaq_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the persistent fault alarm qualifier. A short
// stimulus table covers reset values, limit extremes, every channel class
// and the corner cases of the persistence logic. It is followed by random
// phases, each with its own register setting. Every accepted request is run
// through a local model of the qualifier, and each result is compared field
// by field with the oldest prediction. Both stream sides idle at random,
// except in the final phase.
// ----------------------------------------------------------------------------
module tb;
   import pfaq_pkg::*;

   localparam int COUNTER_BITS    = 12;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 204;
   localparam int PLAN_ROWS       = 33;
   localparam int STALL_LIMIT     = 1000;
   localparam int TAIL_CYCLES     = 4;

   // One row of the directed table: either a register write or a request.
   typedef struct {
      logic            is_write;
      reg_index_type   index;
      logic [15:0]     value;     // register value, or sample of a request
      logic [CH_W-1:0] channel;
      logic            rf;
      logic            typed;     // want holds a hand-written result
      rsp_type         want;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // [3:0] channel, [19:4] sample, [20] rf_enabled, [23:21] zero
   logic [23:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [15:0] alarm_word, [16] reflected_led, [17] current_led,
   // [18] temperature_led, [23:19] zero
   logic [23:0]          rsp_tdata;
   logic                 csr_wr_en = 1'b0;
   logic [IDX_W-1:0]     csr_index = '0;
   logic [LIMIT_W-1:0]   csr_wdata = '0;

   // Local copy of the qualifier state and registers.
   cfg_type              limits_now;
   logic [PERSIST_W-1:0] persist_run [CHANNELS];
   logic [LIMIT_W-1:0]   alarm_now;

   rsp_type              expected_alarms [$];
   int unsigned          mismatch_count = 0;
   logic                 idle_on = 1'b1;
   int unsigned          stall_left = 0;
   int unsigned          quiet_cycles = 0;
   step_row_type         plan [PLAN_ROWS];

   persistent_fault_alarm_qualifier #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the local model by one sample and return the alarm result.
   function automatic rsp_type qualify_sample(input logic [CH_W-1:0] ch,
                                              input logic [15:0] sample,
                                              input logic rf);
      logic                 fault;
      logic [PERSIST_W-1:0] limit;
      logic [PERSIST_W-1:0] count;
      rsp_type              r;
      if (ch != CH_NONE) begin
         if (ch == CH_FORWARD) begin
            fault = sample > limits_now.forward_limit;
            limit = limits_now.power_persist;
         end else if (ch == CH_REFLECTED) begin
            fault = sample > limits_now.reflected_limit;
            limit = limits_now.power_persist;
         end else if (ch <= CH_CURRENT_LAST) begin
            fault = (sample > limits_now.current_high) ||
                    (sample < limits_now.current_low && rf);
            limit = limits_now.current_persist;
         end else begin
            fault = sample > limits_now.temperature_limit;
            limit = limits_now.temperature_persist;
         end
         // A zero limit acts as a limit of one.
         if (limit == '0)
            limit = 12'd1;
         if (fault) begin
            count = persist_run[ch];
            if (count != '1)
               count = count + 1'b1;
            // The counter holds at the limit once the alarm is raised.
            if (count >= limit) begin
               count = limit;
               alarm_now[ch] = 1'b1;
            end else begin
               alarm_now[ch] = 1'b0;
            end
            persist_run[ch] = count;
         end else begin
            persist_run[ch] = '0;
            alarm_now[ch] = 1'b0;
         end
      end
      r.alarm_word      = alarm_now & WORD_MASK;
      r.reflected_led   = r.alarm_word[CH_REFLECTED];
      r.current_led     = |(r.alarm_word & CURRENT_MASK);
      r.temperature_led = |(r.alarm_word & TEMPERATURE_MASK);
      return r;
   endfunction

   // Sample near the fault threshold most of the time, biased toward faults.
   function automatic logic [15:0] sample_near(input logic [15:0] thr);
      logic [15:0] s;
      case ($urandom_range(0, 7))
         0: s = 16'($urandom_range(0, 65535));
         1: s = thr;
         2: s = thr + 1'b1;
         3: s = thr - 1'b1;
         7: s = 16'($urandom_range(0, thr));
         default: s = 16'($urandom_range(thr, 65535));
      endcase
      return s;
   endfunction

   // Register value for a random phase: first all zero, then all ones, then random.
   function automatic logic [15:0] phase_value(input int phase,
                                               input reg_index_type idx);
      if (phase == 0)
         return '0;
      if (phase == 1)
         return '1;
      if (idx >= REG_POWER_PERSIST && $urandom_range(0, 3) != 0)
         return 16'($urandom_range(0, 12));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Write one register once no request is in flight.
   task automatic write_register(input reg_index_type idx, input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_alarms.size() != 0)
         @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_FORWARD_LIMIT:       limits_now.forward_limit       = value;
         REG_REFLECTED_LIMIT:     limits_now.reflected_limit     = value;
         REG_CURRENT_HIGH:        limits_now.current_high        = value;
         REG_CURRENT_LOW:         limits_now.current_low         = value;
         REG_TEMPERATURE_LIMIT:   limits_now.temperature_limit   = value;
         REG_POWER_PERSIST:       limits_now.power_persist       = value[PERSIST_W-1:0];
         REG_CURRENT_PERSIST:     limits_now.current_persist     = value[PERSIST_W-1:0];
         REG_TEMPERATURE_PERSIST: limits_now.temperature_persist = value[PERSIST_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one request and record its expected result on acceptance.
   task automatic send_request(input logic [CH_W-1:0] ch, input logic [15:0] sample,
                               input logic rf, input logic typed, input rsp_type want);
      rsp_type predicted;
      csr_wr_en <= 1'b0;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, rf, sample, ch};
      do
         @(posedge clock);
      while (!req_tready);
      predicted = qualify_sample(ch, sample, rf);
      expected_alarms.push_back(typed ? want : predicted);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Result side: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each delivered result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (expected_alarms.size() == 0) begin
            mismatch_count++;
            $display("%0t: alarm_word expected none, actual %h", $time, got.alarm_word);
         end else begin
            want = expected_alarms.pop_front();
            compare_field("alarm_word", want.alarm_word, got.alarm_word);
            compare_field("reflected_led", 16'(want.reflected_led),
                          16'(got.reflected_led));
            compare_field("current_led", 16'(want.current_led),
                          16'(got.current_led));
            compare_field("temperature_led", 16'(want.temperature_led),
                          16'(got.temperature_led));
         end
      end
   end

   // Watchdog on cycles without any handshake or register write.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      logic [CH_W-1:0] ch;
      logic [15:0]     thr;
      reg_index_type   idx;

      limits_now = '{FORWARD_LIMIT_RST, REFLECTED_LIMIT_RST, CURRENT_HIGH_RST,
                     CURRENT_LOW_RST, TEMPERATURE_LIMIT_RST, POWER_PERSIST_RST,
                     CURRENT_PERSIST_RST, TEMPERATURE_PERSIST_RST};
      foreach (persist_run[i])
         persist_run[i] = '0;
      alarm_now = '0;
      ch = CH_FORWARD;

      // Directed table. Alarm words are typed in where they follow directly
      // from the reset values and limits of one.
      plan = '{
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd1,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd15, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd3,  1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
         // Persistence of zero behaves as one.
         '{1'b1, REG_POWER_PERSIST,       16'd0, 4'd0, 1'b0, 1'b0, '0},
         '{1'b1, REG_CURRENT_PERSIST,     16'd1, 4'd0, 1'b0, 1'b0, '0},
         '{1'b1, REG_TEMPERATURE_PERSIST, 16'd1, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd2401,  4'd1,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0002}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd2,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 16'h0006}},
         // Open-circuit current with RF on, then a low sample with RF off.
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd3,  1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 16'h000E}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd3,     4'd4,  1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 16'h000E}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd231,   4'd6,  1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 16'h004E}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd701,   4'd7,  1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h00CE}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd15, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h80CE}},
         // Channel zero leaves the state alone.
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd0,  1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h80CE}},
         // Samples exactly at the limits are clean.
         '{1'b0, REG_FORWARD_LIMIT, 16'd2400,  4'd1,  1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h80CC}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd4,     4'd3,  1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h80C4}},
         '{1'b0, REG_FORWARD_LIMIT, 16'd230,   4'd6,  1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 16'h8084}},
         // Upper write bits of a persistence register are dropped.
         '{1'b1, REG_TEMPERATURE_PERSIST, 16'hFFFF, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd8,  1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd8,  1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd8,  1'b0, 1'b0, '0},
         // Limit lowered below a running counter: the next fault raises the alarm.
         '{1'b1, REG_TEMPERATURE_PERSIST, 16'd2, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd8,  1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 16'h8184}},
         '{1'b1, REG_FORWARD_LIMIT, 16'hFFFF, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd65535, 4'd1,  1'b1, 1'b0, '0},
         '{1'b1, REG_FORWARD_LIMIT, 16'd0, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd1,     4'd1,  1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd2,  1'b1, 1'b0, '0},
         '{1'b1, REG_CURRENT_LOW, 16'hFFFF, 4'd0, 1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd5,  1'b0, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'd0,     4'd5,  1'b1, 1'b0, '0},
         '{1'b0, REG_FORWARD_LIMIT, 16'hAAAA,  4'd14, 1'b0, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].is_write)
            write_register(plan[r].index, plan[r].value);
         else
            send_request(plan[r].channel, plan[r].value, plan[r].rf,
                         plan[r].typed, plan[r].want);
      end

      // Random phases. Each one starts from a drained pipeline and a full
      // register setting; runs on one channel let the counters build up.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idx = idx.first();
         repeat (idx.num()) begin
            write_register(idx, phase_value(phase, idx));
            idx = idx.next();
         end
         if (phase == RANDOM_PHASES - 1)
            idle_on = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 2) == 0)
               ch = CH_W'($urandom_range(0, CHANNELS - 1));
            if (ch == CH_NONE)
               thr = 16'($urandom_range(0, 65535));
            else if (ch == CH_FORWARD)
               thr = limits_now.forward_limit;
            else if (ch == CH_REFLECTED)
               thr = limits_now.reflected_limit;
            else if (ch <= CH_CURRENT_LAST)
               thr = $urandom_range(0, 1) ? limits_now.current_high : limits_now.current_low;
            else
               thr = limits_now.temperature_limit;
            send_request(ch, sample_near(thr), 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_alarms.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
